>>> hdl/cdq_pkg.sv
// Shared constants and operation codes for the circular deque.
`default_nettype none
package cdq_pkg;
  localparam int DEPTH  = 1024;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CAP_W  = 11;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

  localparam logic [CAP_W-1:0]  CAP_MAX     = CAP_W'(DEPTH);
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;
endpackage
`default_nettype wire

>>> hdl/cdq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hdl/circular_deque_ring_buffer.sv
// Bounded double-ended queue in a ring buffer with a programmable capacity.
//
// Input channel: item_valid / item_stall carry operation and push_value.
// Output channel: result_valid / result_stall carry accepted, front_value,
// rear_value, is_empty and is_full, one result per item.
// Configuration: cfg_write with cfg_data[10:0] sets the capacity (0 reads as
// 1, values above 1024 as 1024) and empties the deque.
// An accepted item updates the pointers and count, writes the entry of a
// push and launches reads of the new front and rear entries in the same
// cycle; the RAM read data then load the result register once that is empty
// or not stalled. No new item is taken until the last one has loaded the
// result register. The two entry RAMs hold identical copies so both ends
// are read at once.
// When result_stall holds a finished result, one more item is taken; its
// read data waits in the RAM output until the result register frees.
// Reset (rst, synchronous) empties the deque with capacity 1024; the entry
// store needs no clearing.
`default_nettype none
module circular_deque_ring_buffer
  import cdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CAP_W-1:0]         cfg_data,
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic [OP_W-1:0]          operation,
  input  wire logic signed [DATA_W-1:0] push_value,
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic                          accepted,
  output logic signed [DATA_W-1:0]      front_value,
  output logic signed [DATA_W-1:0]      rear_value,
  output logic                          is_empty,
  output logic                          is_full
);
  logic [CAP_W-1:0] capacity;
  logic [PTR_W-1:0] front_ptr;
  logic [PTR_W-1:0] rear_ptr;
  logic [CAP_W-1:0] count;
  logic             busy;
  logic             ok;
  logic             fwd_front;
  logic             fwd_rear;
  logic [DATA_W-1:0] fwd_data;

  logic [PTR_W-1:0] front_ptr_next;
  logic [PTR_W-1:0] rear_ptr_next;
  logic [CAP_W-1:0] count_next;
  logic             ok_next;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic             accept;
  logic             load;
  logic [CAP_W-1:0] cap_clamped;
  logic [CAP_W-1:0] front_up;
  logic [CAP_W-1:0] rear_up;
  logic [DATA_W-1:0] front_rdata;
  logic [DATA_W-1:0] rear_rdata;

  assign item_stall = busy;
  assign accept     = item_valid && !busy;
  assign load       = busy && (!result_valid || !result_stall);
  assign front_up   = {1'b0, front_ptr} + CAP_W'(1);
  assign rear_up    = {1'b0, rear_ptr} + CAP_W'(1);

  always_comb begin
    priority if (cfg_data == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (cfg_data > CAP_MAX) begin
      cap_clamped = CAP_MAX;
    end else begin
      cap_clamped = cfg_data;
    end
  end

  always_comb begin
    front_ptr_next = front_ptr;
    rear_ptr_next  = rear_ptr;
    count_next     = count;
    ok_next        = 1'b1;
    we             = 1'b0;
    waddr          = front_ptr;
    unique case (operation)
      OP_PUSH_FRONT: begin
        if (count >= capacity) begin
          ok_next = 1'b0;
        end else begin
          front_ptr_next = (front_ptr == '0) ? PTR_W'(capacity - CAP_W'(1))
                                             : front_ptr - PTR_W'(1);
          count_next     = count + CAP_W'(1);
          we             = 1'b1;
          waddr          = front_ptr_next;
        end
      end
      OP_PUSH_BACK: begin
        if (count >= capacity) begin
          ok_next = 1'b0;
        end else begin
          rear_ptr_next = (rear_up >= capacity) ? '0 : rear_up[PTR_W-1:0];
          count_next    = count + CAP_W'(1);
          we            = 1'b1;
          waddr         = rear_ptr_next;
        end
      end
      OP_POP_FRONT: begin
        if (count == '0) begin
          ok_next = 1'b0;
        end else begin
          front_ptr_next = (front_up >= capacity) ? '0 : front_up[PTR_W-1:0];
          count_next     = count - CAP_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (count == '0) begin
          ok_next = 1'b0;
        end else begin
          rear_ptr_next = (rear_ptr == '0) ? PTR_W'(capacity - CAP_W'(1))
                                           : rear_ptr - PTR_W'(1);
          count_next    = count - CAP_W'(1);
        end
      end
      default: begin
        ok_next = 1'b1;
      end
    endcase
  end

  cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_front_ram (
    .clk   (clk),
    .we    (accept && we),
    .waddr (waddr),
    .wdata (push_value),
    .re    (accept),
    .raddr (front_ptr_next),
    .rdata (front_rdata)
  );

  cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_rear_ram (
    .clk   (clk),
    .we    (accept && we),
    .waddr (waddr),
    .wdata (push_value),
    .re    (accept),
    .raddr (rear_ptr_next),
    .rdata (rear_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_MAX;
      front_ptr <= '0;
      rear_ptr  <= PTR_W'(CAP_MAX - CAP_W'(1));
      count     <= '0;
      busy      <= 1'b0;
    end else if (cfg_write) begin
      capacity  <= cap_clamped;
      front_ptr <= '0;
      rear_ptr  <= PTR_W'(cap_clamped - CAP_W'(1));
      count     <= '0;
    end else if (accept) begin
      front_ptr <= front_ptr_next;
      rear_ptr  <= rear_ptr_next;
      count     <= count_next;
      busy      <= 1'b1;
    end else if (load) begin
      busy      <= 1'b0;
    end
  end

  // hold write data for a same-entry read
  always_ff @(posedge clk) begin
    if (accept) begin
      ok        <= ok_next;
      fwd_front <= we && (waddr == front_ptr_next);
      fwd_rear  <= we && (waddr == rear_ptr_next);
      fwd_data  <= push_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      accepted    <= ok;
      is_empty    <= (count == '0);
      is_full     <= (count == capacity);
      front_value <= (count == '0) ? EMPTY_VALUE
                                   : (fwd_front ? fwd_data : front_rdata);
      rear_value  <= (count == '0) ? EMPTY_VALUE
                                   : (fwd_rear ? fwd_data : rear_rdata);
    end
  end
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the circular deque ring buffer.
`timescale 1ns / 1ps
module tb;
  import cdq_pkg::*;

  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;
  localparam logic [OP_W-1:0] OP_LAST  = 3'd7;
  localparam int STUCK_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic                     empty;
    logic                     full;
  } deque_view_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CAP_W-1:0]         cfg_data = '0;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [OP_W-1:0]          operation = OP_QUERY;
  logic signed [DATA_W-1:0] push_value = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic                     accepted;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] rear_value;
  logic                     is_empty;
  logic                     is_full;

  circular_deque_ring_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .push_value   (push_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .accepted     (accepted),
    .front_value  (front_value),
    .rear_value   (rear_value),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  logic [CAP_W-1:0]  ring_cap = CAP_MAX;
  logic [DATA_W-1:0] ring_store [DEPTH];
  logic [PTR_W-1:0]  ring_head = '0;
  logic [PTR_W-1:0]  ring_tail = PTR_W'(DEPTH - 1);
  logic [CAP_W-1:0]  ring_fill = '0;

  deque_view_t pending_views [$];
  int send_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int items_refused = 0;
  int results_checked = 0;
  int cap_writes = 0;
  int mismatches = 0;
  int stuck_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void load_capacity(logic [CAP_W-1:0] value);
    int c;
    c = int'(value);
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    ring_cap = CAP_W'(c);
    ring_head = '0;
    ring_tail = PTR_W'(c - 1);
    ring_fill = '0;
  endfunction

  function automatic deque_view_t apply_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
    deque_view_t v;
    int c;
    c = int'(ring_cap);
    v.ok = 1'b1;
    case (op)
      OP_PUSH_FRONT: begin
        if (ring_fill >= ring_cap) begin
          v.ok = 1'b0;
        end else begin
          ring_head = (ring_head == 0) ? PTR_W'(c - 1) : ring_head - 1'b1;
          ring_store[ring_head] = val;
          ring_fill++;
        end
      end
      OP_PUSH_BACK: begin
        if (ring_fill >= ring_cap) begin
          v.ok = 1'b0;
        end else begin
          ring_tail = (int'(ring_tail) + 1 >= c) ? '0 : ring_tail + 1'b1;
          ring_store[ring_tail] = val;
          ring_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (ring_fill == 0) begin
          v.ok = 1'b0;
        end else begin
          ring_head = (int'(ring_head) + 1 >= c) ? '0 : ring_head + 1'b1;
          ring_fill--;
        end
      end
      OP_POP_BACK: begin
        if (ring_fill == 0) begin
          v.ok = 1'b0;
        end else begin
          ring_tail = (ring_tail == 0) ? PTR_W'(c - 1) : ring_tail - 1'b1;
          ring_fill--;
        end
      end
      default: begin
      end
    endcase
    if (ring_fill == 0) begin
      v.front = EMPTY_VALUE;
      v.rear = EMPTY_VALUE;
    end else begin
      v.front = ring_store[ring_head];
      v.rear = ring_store[ring_tail];
    end
    v.empty = (ring_fill == 0);
    v.full = (ring_fill == ring_cap);
    return v;
  endfunction

  // Sample both channels mid-cycle, away from the driving edge.
  always @(negedge clk) begin
    deque_view_t got;
    deque_view_t want;
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: no progress for %0d cycles", STUCK_LIMIT);
      $display("tb: failure");
      $finish;
    end
    if (!rst && result_valid && !result_stall) begin
      got = '{accepted, front_value, rear_value, is_empty, is_full};
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb: unexpected result %p", got);
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        results_checked++;
        if (got.ok !== want.ok || got.front !== want.front || got.rear !== want.rear ||
            got.empty !== want.empty || got.full !== want.full) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch on result %0d", results_checked);
            $display("  expected ok=%b front=%0d rear=%0d empty=%b full=%b",
                     want.ok, want.front, want.rear, want.empty, want.full);
            $display("  actual   ok=%b front=%0d rear=%0d empty=%b full=%b",
                     got.ok, got.front, got.rear, got.empty, got.full);
          end
        end
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
    bit taken;
    deque_view_t v;
    while ($urandom_range(99) < send_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    push_value <= val;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    v = apply_item(op, val);
    pending_views = {pending_views, v};
    items_sent++;
    if (!v.ok) items_refused++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    load_capacity(value);
    cap_writes++;
  endtask

  task automatic random_item(int push_pct);
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] val;
    int r;
    r = $urandom_range(99);
    if (r < push_pct) begin
      op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    end else if (r < 96) begin
      op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    end else if (r < 98) begin
      op = OP_QUERY;
    end else begin
      op = OP_LAST - OP_W'($urandom_range(2));
    end
    case ($urandom_range(15))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = '0;
      3: val = '1;
      default: val = $urandom;
    endcase
    send_item(op, val);
  endtask

  task automatic test_empty_at_reset();
    send_item(OP_QUERY, $urandom);
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_LAST - 3'd2, $urandom);
  endtask

  task automatic test_capacity_limits();
    write_capacity('0);
    send_item(OP_PUSH_BACK, 32'h7fff_ffff);
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_LAST, $urandom);
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_BACK, $urandom);
    write_capacity(CAP_W'(2));
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_PUSH_BACK, 32'h7fff_ffff);
    send_item(OP_PUSH_FRONT, '1);
    send_item(OP_LAST - 3'd1, $urandom);
    send_item(OP_POP_BACK, $urandom);
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_FRONT, $urandom);
    write_capacity('1);
    send_item(OP_PUSH_FRONT, '0);
    send_item(OP_PUSH_BACK, '1);
    send_item(OP_POP_FRONT, $urandom);
    send_item(OP_POP_BACK, $urandom);
  endtask

  task automatic test_fill_to_max();
    write_capacity(CAP_MAX);
    send_pct = 0;
    stall_pct = 0;
    repeat (1150) random_item(94);
  endtask

  task automatic test_random_traffic();
    int send_mix [4] = '{0, 80, 0, 23};
    int stall_mix [4] = '{0, 0, 80, 23};
    int push_mix [3] = '{35, 50, 65};
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 3; p++) begin
        if ($urandom_range(99) < 80) begin
          write_capacity(CAP_W'($urandom_range(1, 10)));
        end else begin
          write_capacity(CAP_W'($urandom_range(2047)));
        end
        send_pct = send_mix[m];
        stall_pct = stall_mix[m];
        repeat (20) random_item(push_mix[p]);
      end
    end
    send_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_at_reset();
    test_capacity_limits();
    test_fill_to_max();
    test_random_traffic();
    drain();
    if (pending_views.size() != 0) begin
      mismatches++;
      $display("tb: %0d results never arrived", pending_views.size());
    end
    $display("tb: %0d items (%0d refused) checked across %0d capacity writes,",
             items_sent, items_refused, cap_writes);
    $display("tb: with sender gaps and receiver stalls in turn; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
